// File: rtl/core/pba_pkg.sv
package pba_pkg;

    // Field widths of the request and result beats
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 32;
    localparam int PADDR_W  = 27;
    localparam int STATUS_W = 2;

    // Default geometry of the page bitmap
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC     = 2'd0,
        FN_FREE      = 2'd1,
        FN_MARK_USED = 2'd2,
        FN_MARK_FREE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_OOM    = 2'd1,
        ST_BEYOND = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture a request beat
        logic prep;      // resolve region bounds
        logic clear;     // zero one bitmap word
        logic scan;      // first-fit search
        logic sweep;     // region read-modify-write
        logic out_load;  // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic empty;
        logic scan_done;
        logic sweep_done;
    } t_sts;

endpackage

// File: rtl/core/pba_ram.sv
module pba_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pba_dp.sv
module pba_dp #(
    parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
    parameter int WORD_BITS  = pba_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pba_pkg::t_cmd                 i_cmd,
    output pba_pkg::t_sts                 o_sts,
    input  logic [pba_pkg::FUNC_W-1:0]    i_func,
    input  logic [pba_pkg::ADDR_W-1:0]    i_byte_address,
    input  logic [pba_pkg::LEN_W-1:0]     i_region_bytes,
    output logic [pba_pkg::PADDR_W-1:0]   o_page_address,
    output logic [pba_pkg::STATUS_W-1:0]  o_status
);

    import pba_pkg::*;

    localparam int WB_LOG2    = $clog2(WORD_BITS);
    localparam int PB_LOG2    = $clog2(PAGE_BYTES);
    localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PTR_W      = WA + 1;
    localparam int PG_W       = $clog2(NUM_PAGES + 1);
    localparam int FP_W       = ADDR_W - PB_LOG2;
    localparam int CNT_W      = LEN_W + 1 - PB_LOG2;
    localparam int IDX_W      = WA + WB_LOG2;
    localparam int SR_W       = ADDR_W + 2;
    localparam int LAST_BITS  = NUM_PAGES - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] ONES      = '1;
    localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);

    // Index of the single set bit
    function automatic logic [WB_LOG2-1:0] onehot_index(input logic [WORD_BITS-1:0] onehot);
        logic [WB_LOG2-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            idx = idx | (WB_LOG2'(b) & {WB_LOG2{onehot[b]}});
        end
        return idx;
    endfunction

    logic                 r_set;
    logic [FP_W-1:0]      r_first;
    logic [CNT_W-1:0]     r_cnt;
    logic [PG_W-1:0]      r_stop;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [WA-1:0]        r_dat_ptr;
    logic                 r_dat_vld;
    logic [PADDR_W-1:0]   r_res_addr;
    t_status              r_res_status;
    logic [PADDR_W-1:0]   r_page_address;
    t_status              r_status;

    logic [WA-1:0]        first_word;
    logic [PG_W-1:0]      last_pg;
    logic [WA-1:0]        last_word;
    logic                 issue;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_bit;
    logic                 found;
    logic [IDX_W-1:0]     page_idx;
    logic [63:0]          page_byte;
    logic [WB_LOG2-1:0]   lo_off;
    logic [WB_LOG2-1:0]   hi_off;
    logic [WORD_BITS-1:0] region_mask;
    logic [SR_W-1:0]      stop_raw;
    logic                 beyond;
    logic                 empty;
    logic [CNT_W-1:0]     load_cnt;
    logic                 we;
    logic [WA-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 last_scan_word;

    // Region bounds in words
    assign first_word = WA'(r_first >> WB_LOG2);
    assign last_pg    = r_stop - PG_W'(1);
    assign last_word  = WA'(last_pg >> WB_LOG2);

    // Read issue: one word a cycle while the range lasts
    always_comb begin
        issue = 1'b0;
        if (i_cmd.scan) begin
            issue = (r_rd_ptr < PTR_W'(WORD_COUNT));
        end else if (i_cmd.sweep) begin
            issue = (r_rd_ptr <= {1'b0, last_word});
        end
    end

    // First-fit search on the returned word
    assign last_scan_word = (r_dat_ptr == WA'(WORD_COUNT - 1));
    assign word_mask      = last_scan_word ? LAST_MASK : ONES;
    assign free_bits      = ~rd_data & word_mask;
    assign low_bit        = free_bits & (~free_bits + WORD_BITS'(1));
    assign found          = |free_bits;
    assign page_idx       = {r_dat_ptr, onehot_index(low_bit)};
    assign page_byte      = 64'(page_idx) << PB_LOG2;

    // Region bit mask for the returned word
    assign lo_off      = (r_dat_ptr == first_word) ? r_first[WB_LOG2-1:0] : '0;
    assign hi_off      = (r_dat_ptr == last_word) ? last_pg[WB_LOG2-1:0] : '1;
    assign region_mask = (ONES << lo_off) & (ONES >> (~hi_off));

    // Region end and clamp
    assign stop_raw = SR_W'(r_first) + SR_W'(r_cnt);
    assign beyond   = (stop_raw > SR_W'(NUM_PAGES));
    assign empty    = (r_cnt == '0) || (SR_W'(r_first) >= SR_W'(NUM_PAGES));

    // Page count of the incoming beat, rounded up; a free always counts one page
    always_comb begin
        if (i_func == FN_FREE) begin
            load_cnt = CNT_W'(1);
        end else begin
            load_cnt = CNT_W'(((LEN_W + 1)'(i_region_bytes) + (LEN_W + 1)'(PAGE_BYTES - 1))
                              >> PB_LOG2);
        end
    end

    // Write port select
    always_comb begin
        we    = 1'b0;
        waddr = r_dat_ptr;
        wdata = rd_data;
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_rd_ptr[WA-1:0];
            wdata = '0;
        end else if (i_cmd.scan) begin
            we    = r_dat_vld && found;
            wdata = rd_data | low_bit;
        end else if (i_cmd.sweep) begin
            we    = r_dat_vld;
            wdata = r_set ? (rd_data | region_mask) : (rd_data & ~region_mask);
        end
    end

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_rd_ptr[WA-1:0]),
        .o_rdata (rd_data)
    );

    // Pointer and read-pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_dat_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_ptr  <= '0;
            r_dat_vld <= 1'b0;
        end else if (i_cmd.prep) begin
            r_rd_ptr  <= {1'b0, first_word};
            r_dat_vld <= 1'b0;
        end else if (i_cmd.clear) begin
            r_rd_ptr  <= r_rd_ptr + PTR_W'(1);
        end else if (i_cmd.scan || i_cmd.sweep) begin
            r_rd_ptr  <= issue ? (r_rd_ptr + PTR_W'(1)) : r_rd_ptr;
            r_dat_vld <= issue;
        end
    end

    // Request, result and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set        <= (i_func == FN_MARK_USED);
            r_first      <= FP_W'(i_byte_address >> PB_LOG2);
            r_cnt        <= load_cnt;
            r_res_addr   <= '0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.prep) begin
            r_stop       <= beyond ? PG_W'(NUM_PAGES) : PG_W'(stop_raw);
            r_res_status <= (beyond && (r_cnt != '0)) ? ST_BEYOND : ST_OK;
        end
        if (i_cmd.scan || i_cmd.sweep) begin
            r_dat_ptr <= r_rd_ptr[WA-1:0];
        end
        if (i_cmd.scan && o_sts.scan_done) begin
            r_res_addr   <= found ? page_byte[PADDR_W-1:0] : '0;
            r_res_status <= found ? ST_OK : ST_OOM;
        end
        if (i_cmd.out_load) begin
            r_page_address <= r_res_addr;
            r_status       <= r_res_status;
        end
    end

    // Status back to the controller
    assign o_sts.clear_done = i_cmd.clear && (r_rd_ptr == PTR_W'(WORD_COUNT - 1));
    assign o_sts.empty      = empty;
    assign o_sts.scan_done  = r_dat_vld && (found || last_scan_word);
    assign o_sts.sweep_done = r_dat_vld && (r_dat_ptr == last_word);

    assign o_page_address = r_page_address;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && r_dat_vld) |-> (r_dat_ptr >= first_word && r_dat_ptr <= last_word))
        else $error("region write outside its word range");

    a_alloc_in_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_dat_vld && found) |-> (64'(page_idx) < 64'(NUM_PAGES)))
        else $error("allocated page lies beyond the bitmap");

    a_scan_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_dat_vld) |-> (r_dat_ptr <= WA'(WORD_COUNT - 1)))
        else $error("scan pointer ran past the last word");
`endif

endmodule

// File: rtl/core/pba_ctrl.sv
module pba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [pba_pkg::FUNC_W-1:0] i_func,
    output logic                       o_valid,
    input  logic                       i_stall,
    output pba_pkg::t_cmd              o_cmd,
    input  pba_pkg::t_sts              i_sts
);

    import pba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_SWEEP,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   accept;
    logic   out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_stall;

    // Commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.sweep    = (r_state == S_SWEEP);
        o_cmd.out_load = (r_state == S_RESULT) && out_free;
    end

    // Sequence one request; hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= (i_func == FN_ALLOC) ? S_SCAN : S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= i_sts.empty ? S_RESULT : S_SWEEP;
                end
                S_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_SWEEP: begin
                    if (i_sts.sweep_done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_vld || !i_stall))
        else $error("result register loaded while a stalled beat waits");

    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_RESULT))
        else $error("result beat raised outside the result step");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without leaving idle");
`endif

endmodule

// File: rtl/core/page_bitmap_allocator.sv
// First-fit page frame allocator over a bitmap of NUM_PAGES used bits, kept in one
// RAM of NUM_PAGES/WORD_BITS words, rounded up. After reset the block zeroes the RAM
// one word a cycle and holds o_stall high meanwhile. Requests are handled one at a
// time; the search and region walks read one word per cycle through the RAM's
// registered read port and write back in the next. Allocate reads from the first
// word up to the first word holding a free page (every word when memory is full);
// free and mark-region walk the words the region touches, and nothing is written
// for an empty region or a start beyond the table. PAGE_BYTES and WORD_BITS must be
// powers of two. A result beat may wait in the output register while the next
// request is accepted.
module page_bitmap_allocator #(
    parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
    parameter int WORD_BITS  = pba_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pba_pkg::FUNC_W-1:0]    i_func,
    input  logic [pba_pkg::ADDR_W-1:0]    i_byte_address,
    input  logic [pba_pkg::LEN_W-1:0]     i_region_bytes,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pba_pkg::PADDR_W-1:0]   o_page_address,
    output logic [pba_pkg::STATUS_W-1:0]  o_status
);

    import pba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    pba_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_byte_address (i_byte_address),
        .i_region_bytes (i_region_bytes),
        .o_page_address (o_page_address),
        .o_status       (o_status)
    );

endmodule
